// ===== rtl/core/cpmg_pkg.sv =====
package cpmg_pkg;

	// Sample path and capture limits
	localparam int BUFFER_DEPTH = 4096;
	localparam int SAMPLE_BITS  = 12;
	localparam logic [11:0] SAMPLE_MASK = 12'((32'd1 << SAMPLE_BITS) - 32'd1);

	// Configuration port
	localparam int CFG_INDEX_W = 4;
	localparam int CFG_DATA_W  = 32;

	localparam logic [CFG_INDEX_W-1:0] REG_HALF_CYCLE      = 4'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_PULSE_CYCLES    = 4'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_DEAD            = 4'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_POLARIZE        = 4'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_HALF_ECHO       = 4'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_INTERVAL = 4'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_POINTS          = 4'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_ECHO_COUNT      = 4'd7;

	// Register values after reset
	localparam logic [15:0] RST_HALF_CYCLE      = 16'd500;
	localparam logic [15:0] RST_PULSE_CYCLES    = 16'd10;
	localparam logic [23:0] RST_DEAD            = 24'd1000;
	localparam logic [31:0] RST_POLARIZE        = 32'd1000000;
	localparam logic [23:0] RST_HALF_ECHO       = 24'd5000;
	localparam logic [15:0] RST_SAMPLE_INTERVAL = 16'd100;
	localparam logic [12:0] RST_POINTS          = 13'd4096;
	localparam logic [7:0]  RST_ECHO_COUNT      = 8'd1;

	typedef struct packed {
		logic        command;
		logic [11:0] adc_sample;
	} item_t;

	typedef struct packed {
		logic        tx_positive;
		logic        tx_negative;
		logic        transmit_mode;
		logic        polarize_on;
		logic        ramp_strobe;
		logic        sample_valid;
		logic [11:0] captured_sample;
		logic [7:0]  echo_number;
		logic        last_of_echo;
		logic        busy_res;
	} result_t;

endpackage

// ===== rtl/core/nmr_cpmg_pulse_sequencer.sv =====
// Each accepted tick's result goes into the output register, or into the skid register
// while the output is stalled. Throughput: one tick or start command per cycle while
// item_stall is low; every tick is resolved in a single pass through the phase counters,
// including skipping of zero-length phases. A two-entry output stage (result register
// plus skid register) raises item_stall only while the skid register holds a result.
// Reset (arst_n low): sequencer idle, counters cleared, registers back to their defaults.
module nmr_cpmg_pulse_sequencer (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             item_valid,
	output logic                             item_stall,
	input  cpmg_pkg::item_t                  item,
	output logic                             result_valid,
	input  logic                             result_stall,
	output cpmg_pkg::result_t                result,
	input  logic                             cfg_write,
	input  logic [cpmg_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [cpmg_pkg::CFG_DATA_W-1:0]  cfg_data
);

	// Phase codes; TX/DEAD are split by pulse type so the 180 flag lives in the code
	localparam logic [3:0] PH_IDLE     = 4'd0;
	localparam logic [3:0] PH_POLARIZE = 4'd1;
	localparam logic [3:0] PH_RAMP     = 4'd2;
	localparam logic [3:0] PH_TX90     = 4'd3;
	localparam logic [3:0] PH_DEAD90   = 4'd4;
	localparam logic [3:0] PH_WAIT1    = 4'd5;
	localparam logic [3:0] PH_TX180    = 4'd6;
	localparam logic [3:0] PH_DEAD180  = 4'd7;
	localparam logic [3:0] PH_WAIT2    = 4'd8;
	localparam logic [3:0] PH_SAMPLE   = 4'd9;
	// Entry point past the sample phase: count the echo, then loop or finish
	localparam logic [3:0] ENT_WRAP    = 4'd10;

	// Configuration registers
	logic [15:0] half_cycle_q;
	logic [15:0] pulse_cycles_q;
	logic [23:0] dead_q;
	logic [31:0] polarize_q;
	logic [23:0] half_echo_q;
	logic [15:0] interval_q;
	logic [12:0] points_q;
	logic [7:0]  echo_count_q;

	// Sequencer state
	logic [3:0]  phase_q;
	logic [31:0] tick_q;
	logic [16:0] cycle_q;
	logic        neg_q;
	logic [7:0]  echo_done_q;
	logic [12:0] sample_cnt_q;

	// Output stage
	logic                result_valid_q;
	cpmg_pkg::result_t   result_q;
	logic                skid_valid_q;
	cpmg_pkg::result_t   skid_q;

	logic take;
	logic out_free;

	// Derived limits
	logic [15:0] half_cycle_eff;
	logic [15:0] interval_eff;
	logic [7:0]  echo_target;
	logic [12:0] points_limit;
	logic [16:0] burst;
	logic [9:0]  nonempty;

	// Next state
	logic [3:0]  phase_n;
	logic [31:0] tick_n;
	logic [16:0] cycle_n;
	logic        neg_n;
	logic [7:0]  echo_done_n;
	logic [12:0] sample_cnt_n;
	logic [31:0] tick_inc;
	logic [16:0] cycle_inc;
	logic [12:0] sample_inc;

	logic        adv;
	logic [3:0]  entry;
	logic [7:0]  ed_base;
	logic [7:0]  ed_inc;
	logic [9:0]  mask_a;
	logic [9:0]  mask_b;
	cpmg_pkg::result_t res;

	function automatic logic [3:0] first_set(input logic [9:0] m);
		logic [3:0] r;
		r = PH_IDLE;
		for (int i = 9; i >= 1; i--) begin
			if (m[i]) r = 4'(i);
		end
		return r;
	endfunction

	assign item_stall   = skid_valid_q;
	assign take         = item_valid && !skid_valid_q;
	assign out_free     = !result_valid_q || !result_stall;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	assign half_cycle_eff = (half_cycle_q == 16'd0) ? 16'd1 : half_cycle_q;
	assign interval_eff   = (interval_q == 16'd0) ? 16'd1 : interval_q;
	assign echo_target    = (echo_count_q == 8'd0) ? 8'd1 : echo_count_q;
	assign points_limit   = ({4'd0, points_q} > 17'(cpmg_pkg::BUFFER_DEPTH)) ?
		13'(cpmg_pkg::BUFFER_DEPTH) : points_q;
	assign burst          = (phase_q == PH_TX180) ? {pulse_cycles_q, 1'b0} :
		{1'b0, pulse_cycles_q};

	always_comb begin
		nonempty              = '0;
		nonempty[PH_POLARIZE] = (polarize_q != 32'd0);
		nonempty[PH_RAMP]     = 1'b1;
		nonempty[PH_TX90]     = (pulse_cycles_q != 16'd0);
		nonempty[PH_DEAD90]   = (dead_q != 24'd0);
		nonempty[PH_WAIT1]    = (half_echo_q != 24'd0);
		nonempty[PH_TX180]    = (pulse_cycles_q != 16'd0);
		nonempty[PH_DEAD180]  = (dead_q != 24'd0);
		nonempty[PH_WAIT2]    = (half_echo_q != 24'd0);
		nonempty[PH_SAMPLE]   = (points_limit != 13'd0);
	end

	assign tick_inc   = tick_q + 32'd1;
	assign cycle_inc  = cycle_q + 17'd1;
	assign sample_inc = sample_cnt_q + 13'd1;

	always_comb begin
		res          = '0;
		phase_n      = phase_q;
		tick_n       = tick_q;
		cycle_n      = cycle_q;
		neg_n        = neg_q;
		echo_done_n  = echo_done_q;
		sample_cnt_n = sample_cnt_q;
		adv          = 1'b0;
		entry        = PH_IDLE;
		ed_base      = echo_done_q;

		case (phase_q)
			PH_IDLE: begin
				if (item.command) begin
					res.busy_res = 1'b1;
					adv          = 1'b1;
					entry        = PH_POLARIZE;
					ed_base      = 8'd0;
				end
			end
			PH_POLARIZE: begin
				res.busy_res    = 1'b1;
				res.polarize_on = 1'b1;
				tick_n          = tick_inc;
				if (tick_inc >= polarize_q) begin
					adv   = 1'b1;
					entry = PH_TX90 - 4'd1;
				end
			end
			PH_RAMP: begin
				res.busy_res    = 1'b1;
				res.ramp_strobe = 1'b1;
				adv             = 1'b1;
				entry           = PH_TX90;
			end
			PH_TX90, PH_TX180: begin
				res.busy_res      = 1'b1;
				res.transmit_mode = 1'b1;
				res.tx_positive   = !neg_q;
				res.tx_negative   = neg_q;
				tick_n            = tick_inc;
				if (tick_inc >= {16'd0, half_cycle_eff}) begin
					tick_n = 32'd0;
					if (neg_q) begin
						neg_n   = 1'b0;
						cycle_n = cycle_inc;
						if (cycle_inc >= burst) begin
							adv   = 1'b1;
							entry = (phase_q == PH_TX180) ? PH_DEAD180 : PH_DEAD90;
						end
					end else begin
						neg_n = 1'b1;
					end
				end
			end
			PH_DEAD90, PH_DEAD180: begin
				res.busy_res = 1'b1;
				tick_n       = tick_inc;
				if (tick_inc >= {8'd0, dead_q}) begin
					adv   = 1'b1;
					entry = (phase_q == PH_DEAD180) ? PH_WAIT2 : PH_WAIT1;
				end
			end
			PH_WAIT1, PH_WAIT2: begin
				res.busy_res = 1'b1;
				tick_n       = tick_inc;
				if (tick_inc >= {8'd0, half_echo_q}) begin
					adv   = 1'b1;
					entry = (phase_q == PH_WAIT2) ? PH_SAMPLE : PH_TX180;
				end
			end
			PH_SAMPLE: begin
				res.busy_res = 1'b1;
				if (tick_q == 32'd0) begin
					res.sample_valid    = 1'b1;
					res.captured_sample = item.adc_sample & cpmg_pkg::SAMPLE_MASK;
					res.echo_number     = echo_done_q;
					res.last_of_echo    = (sample_inc >= points_limit);
				end
				tick_n = tick_inc;
				if (tick_inc >= {16'd0, interval_eff}) begin
					tick_n       = 32'd0;
					sample_cnt_n = sample_inc;
					if (sample_inc >= points_limit) begin
						adv   = 1'b1;
						entry = ENT_WRAP;
					end
				end
			end
			default: begin
				phase_n = PH_IDLE;
			end
		endcase

		// Skip zero-length phases: first nonempty phase at or past the entry, else
		// count the echo and try the echo loop once more.
		for (int i = 0; i < 10; i++) begin
			mask_a[i] = nonempty[i] && (4'(i) >= entry);
			mask_b[i] = nonempty[i] && (4'(i) >= PH_WAIT1);
		end
		ed_inc = ed_base + 8'd1;

		if (adv) begin
			tick_n       = 32'd0;
			cycle_n      = 17'd0;
			neg_n        = 1'b0;
			sample_cnt_n = 13'd0;
			if (|mask_a) begin
				phase_n     = first_set(mask_a);
				echo_done_n = ed_base;
			end else begin
				echo_done_n = ed_inc;
				if (ed_inc >= echo_target || !(|mask_b)) begin
					phase_n = PH_IDLE;
				end else begin
					phase_n = first_set(mask_b);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			tick_q       <= '0;
			cycle_q      <= '0;
			neg_q        <= 1'b0;
			echo_done_q  <= '0;
			sample_cnt_q <= '0;
		end else if (take) begin
			phase_q      <= phase_n;
			tick_q       <= tick_n;
			cycle_q      <= cycle_n;
			neg_q        <= neg_n;
			echo_done_q  <= echo_done_n;
			sample_cnt_q <= sample_cnt_n;
		end
	end

	// Refuse writes while a run is in progress
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_cycle_q   <= cpmg_pkg::RST_HALF_CYCLE;
			pulse_cycles_q <= cpmg_pkg::RST_PULSE_CYCLES;
			dead_q         <= cpmg_pkg::RST_DEAD;
			polarize_q     <= cpmg_pkg::RST_POLARIZE;
			half_echo_q    <= cpmg_pkg::RST_HALF_ECHO;
			interval_q     <= cpmg_pkg::RST_SAMPLE_INTERVAL;
			points_q       <= cpmg_pkg::RST_POINTS;
			echo_count_q   <= cpmg_pkg::RST_ECHO_COUNT;
		end else if (cfg_write && phase_q == PH_IDLE) begin
			case (cfg_index)
				cpmg_pkg::REG_HALF_CYCLE:      half_cycle_q   <= cfg_data[15:0];
				cpmg_pkg::REG_PULSE_CYCLES:    pulse_cycles_q <= cfg_data[15:0];
				cpmg_pkg::REG_DEAD:            dead_q         <= cfg_data[23:0];
				cpmg_pkg::REG_POLARIZE:        polarize_q     <= cfg_data[31:0];
				cpmg_pkg::REG_HALF_ECHO:       half_echo_q    <= cfg_data[23:0];
				cpmg_pkg::REG_SAMPLE_INTERVAL: interval_q     <= cfg_data[15:0];
				cpmg_pkg::REG_POINTS:          points_q       <= cfg_data[12:0];
				cpmg_pkg::REG_ECHO_COUNT:      echo_count_q   <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Output register with skid: drain the skid first to keep transaction order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
			skid_valid_q   <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				result_valid_q <= 1'b1;
				skid_valid_q   <= 1'b0;
			end else begin
				result_valid_q <= take;
			end
		end else if (take) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				result_q <= skid_q;
			end else if (take) begin
				result_q <= res;
			end
		end else if (take) begin
			skid_q <= res;
		end
	end

	a_skid_behind_result: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> result_valid_q)
		else $error("skid register full while result register empty");

	a_start_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		take && phase_q == PH_IDLE && item.command |=> phase_q != PH_IDLE)
		else $error("start command did not launch a run");

	a_cycle_in_burst: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_TX90 || phase_q == PH_TX180) |-> cycle_q < burst)
		else $error("carrier cycle count past burst length");

	a_sample_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_SAMPLE |-> sample_cnt_q < points_limit)
		else $error("sample count past points limit");

	a_echo_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_WAIT1 || phase_q == PH_TX180 || phase_q == PH_DEAD180 ||
		 phase_q == PH_WAIT2 || phase_q == PH_SAMPLE) |-> echo_done_q < echo_target)
		else $error("echo index past echo count");

endmodule

// ===== bench/nmr_cpmg_pulse_sequencer_tb.sv =====
`timescale 1ns / 1ps

module nmr_cpmg_pulse_sequencer_tb;

	localparam int ITEM_GOAL      = 1700;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TAIL_CYCLES    = 8;

	typedef logic [cpmg_pkg::CFG_INDEX_W-1:0] cfg_index_t;
	typedef logic [cpmg_pkg::CFG_DATA_W-1:0]  cfg_data_t;

	localparam cfg_index_t REG_SPARE_FIRST = cpmg_pkg::REG_ECHO_COUNT + 1'b1;
	localparam cfg_index_t REG_SPARE_LAST  = '1;

	typedef enum logic [3:0] {
		S_IDLE, S_POLARIZE, S_RAMP, S_BURST, S_SETTLE, S_PRE_ECHO, S_POST_ECHO, S_ACQUIRE
	} stage_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	cpmg_pkg::item_t item = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	cpmg_pkg::result_t result;
	logic cfg_write = 1'b0;
	cfg_index_t cfg_index = '0;
	cfg_data_t cfg_data = '0;

	// sequencer image: register copies and phase counters
	logic [15:0] hcycle_ticks  = cpmg_pkg::RST_HALF_CYCLE;
	logic [15:0] pulses_90     = cpmg_pkg::RST_PULSE_CYCLES;
	logic [23:0] dead_len      = cpmg_pkg::RST_DEAD;
	logic [31:0] polarize_len  = cpmg_pkg::RST_POLARIZE;
	logic [23:0] half_echo_len = cpmg_pkg::RST_HALF_ECHO;
	logic [15:0] interval_len  = cpmg_pkg::RST_SAMPLE_INTERVAL;
	logic [12:0] points_cfg    = cpmg_pkg::RST_POINTS;
	logic [7:0]  echoes_cfg    = cpmg_pkg::RST_ECHO_COUNT;
	stage_t      stage         = S_IDLE;
	logic [31:0] stage_ticks   = '0;
	logic [16:0] burst_done    = '0;
	logic        neg_half      = 1'b0;
	logic        refocus       = 1'b0;
	logic [7:0]  echoes_done   = '0;
	logic [12:0] points_done   = '0;

	cpmg_pkg::item_t   tick_queue[$];
	cpmg_pkg::result_t outputs_due[$];
	cpmg_pkg::result_t want;

	int stim_items, runs_started, samples_taken, reg_writes, mismatches;
	int quiet_cycles, send_gap, recv_gap, send_gap_pct, recv_gap_pct;
	bit quiet_tail;

	nmr_cpmg_pulse_sequencer dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [16:0] burst_len();
		return refocus ? {pulses_90, 1'b0} : {1'b0, pulses_90};
	endfunction

	function automatic logic [12:0] point_total();
		return (points_cfg > cpmg_pkg::BUFFER_DEPTH) ? 13'(cpmg_pkg::BUFFER_DEPTH) : points_cfg;
	endfunction

	function automatic bit stage_skipped(stage_t s);
		case (s)
		S_POLARIZE: return polarize_len == 0;
		S_BURST: return burst_len() == 0;
		S_SETTLE: return dead_len == 0;
		S_PRE_ECHO, S_POST_ECHO: return half_echo_len == 0;
		S_ACQUIRE: return point_total() == 0;
		default: return 1'b0;
		endcase
	endfunction

	function automatic stage_t stage_after(stage_t s);
		case (s)
		S_POLARIZE: return S_RAMP;
		S_RAMP: begin
			refocus = 1'b0;
			return S_BURST;
		end
		S_BURST: return S_SETTLE;
		S_SETTLE: return refocus ? S_POST_ECHO : S_PRE_ECHO;
		S_PRE_ECHO: begin
			refocus = 1'b1;
			return S_BURST;
		end
		S_POST_ECHO: return S_ACQUIRE;
		S_ACQUIRE: begin
			echoes_done = echoes_done + 1'b1;
			return (echoes_done >= ((echoes_cfg == 0) ? 8'd1 : echoes_cfg)) ? S_IDLE : S_PRE_ECHO;
		end
		default: return S_IDLE;
		endcase
	endfunction

	// zero-length phases fall through in the same tick
	function automatic void open_stage(stage_t s);
		stage = s;
		forever begin
			stage_ticks = '0;
			burst_done = '0;
			neg_half = 1'b0;
			points_done = '0;
			if (!stage_skipped(stage))
				return;
			stage = stage_after(stage);
		end
	endfunction

	function automatic cpmg_pkg::result_t sequence_tick(cpmg_pkg::item_t it);
		cpmg_pkg::result_t r;
		r = '0;
		if (stage == S_IDLE) begin
			if (it.command) begin
				echoes_done = '0;
				refocus = 1'b0;
				open_stage(S_POLARIZE);
				r.busy_res = 1'b1;
				runs_started++;
			end
			return r;
		end
		r.busy_res = 1'b1;
		case (stage)
		S_POLARIZE: begin
			r.polarize_on = 1'b1;
			stage_ticks = stage_ticks + 1;
			if (stage_ticks >= polarize_len)
				open_stage(stage_after(stage));
		end
		S_RAMP: begin
			r.ramp_strobe = 1'b1;
			open_stage(stage_after(stage));
		end
		S_BURST: begin
			r.transmit_mode = 1'b1;
			r.tx_positive = !neg_half;
			r.tx_negative = neg_half;
			stage_ticks = stage_ticks + 1;
			if (stage_ticks >= ((hcycle_ticks == 0) ? 16'd1 : hcycle_ticks)) begin
				stage_ticks = '0;
				if (neg_half) begin
					neg_half = 1'b0;
					burst_done = burst_done + 1'b1;
					if (burst_done >= burst_len())
						open_stage(stage_after(stage));
				end else begin
					neg_half = 1'b1;
				end
			end
		end
		S_SETTLE: begin
			stage_ticks = stage_ticks + 1;
			if (stage_ticks >= dead_len)
				open_stage(stage_after(stage));
		end
		S_PRE_ECHO, S_POST_ECHO: begin
			stage_ticks = stage_ticks + 1;
			if (stage_ticks >= half_echo_len)
				open_stage(stage_after(stage));
		end
		S_ACQUIRE: begin
			if (stage_ticks == 0) begin
				r.sample_valid = 1'b1;
				r.captured_sample = it.adc_sample & cpmg_pkg::SAMPLE_MASK;
				r.echo_number = echoes_done;
				r.last_of_echo = (points_done + 13'd1 >= point_total());
				samples_taken++;
			end
			stage_ticks = stage_ticks + 1;
			if (stage_ticks >= ((interval_len == 0) ? 16'd1 : interval_len)) begin
				stage_ticks = '0;
				points_done = points_done + 1'b1;
				if (points_done >= point_total())
					open_stage(stage_after(stage));
			end
		end
		default: stage = S_IDLE;
		endcase
		return r;
	endfunction

	// writes are refused while a sequence runs
	function automatic void apply_write(cfg_index_t idx, cfg_data_t data);
		if (stage != S_IDLE)
			return;
		case (idx)
		cpmg_pkg::REG_HALF_CYCLE: hcycle_ticks = data[15:0];
		cpmg_pkg::REG_PULSE_CYCLES: pulses_90 = data[15:0];
		cpmg_pkg::REG_DEAD: dead_len = data[23:0];
		cpmg_pkg::REG_POLARIZE: polarize_len = data;
		cpmg_pkg::REG_HALF_ECHO: half_echo_len = data[23:0];
		cpmg_pkg::REG_SAMPLE_INTERVAL: interval_len = data[15:0];
		cpmg_pkg::REG_POINTS: points_cfg = data[12:0];
		cpmg_pkg::REG_ECHO_COUNT: echoes_cfg = data[7:0];
		default: ;
		endcase
	endfunction

	function automatic int run_length();
		int hc, iv, ec, tx;
		hc = (hcycle_ticks == 0) ? 1 : int'(hcycle_ticks);
		iv = (interval_len == 0) ? 1 : int'(interval_len);
		ec = (echoes_cfg == 0) ? 1 : int'(echoes_cfg);
		tx = 2 * hc * int'(pulses_90);
		return int'(polarize_len) + 1 + tx + int'(dead_len)
			+ ec * (2 * int'(half_echo_len) + 2 * tx + int'(dead_len) + int'(point_total()) * iv);
	endfunction

	function automatic void check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
		if (act_val !== exp_val) begin
			mismatches++;
			$error("%s: expected 'h%0h, got 'h%0h", name, exp_val, act_val);
		end
	endfunction

	function automatic void queue_tick(logic cmd, logic [11:0] adc);
		cpmg_pkg::item_t t;
		t.command = cmd;
		t.adc_sample = adc;
		tick_queue = {tick_queue, t};
		stim_items++;
	endfunction

	function automatic void queue_ticks(int n, int start_pct);
		for (int i = 0; i < n; i++)
			queue_tick($urandom_range(0, 99) < start_pct, 12'($urandom()));
	endfunction

	task automatic wait_drained();
		do @(negedge clk);
		while (tick_queue.size() != 0 || item_valid || outputs_due.size() != 0);
	endtask

	task automatic write_reg(input cfg_index_t idx, input cfg_data_t data);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_write <= 1'b0;
		apply_write(idx, data);
		reg_writes++;
	endtask

	task automatic set_timing(input logic [31:0] hc, pc, dead, pol, he, iv, pts, ech);
		write_reg(cpmg_pkg::REG_HALF_CYCLE, hc);
		write_reg(cpmg_pkg::REG_PULSE_CYCLES, pc);
		write_reg(cpmg_pkg::REG_DEAD, dead);
		write_reg(cpmg_pkg::REG_POLARIZE, pol);
		write_reg(cpmg_pkg::REG_HALF_ECHO, he);
		write_reg(cpmg_pkg::REG_SAMPLE_INTERVAL, iv);
		write_reg(cpmg_pkg::REG_POINTS, pts);
		write_reg(cpmg_pkg::REG_ECHO_COUNT, ech);
	endtask

	// one full sequence; optionally hold off mid-run and try a write that must be refused
	task automatic run_sequence(input bit pause_mid);
		int len, cut;
		len = run_length();
		cut = pause_mid ? int'($urandom_range(0, len - 1)) : len;
		queue_tick(1'b1, 12'($urandom()));
		queue_ticks(cut, 4);
		if (pause_mid) begin
			wait_drained();
			write_reg(cfg_index_t'($urandom_range(0, cpmg_pkg::REG_ECHO_COUNT)), $urandom());
			queue_ticks(len - cut, 4);
		end
		queue_ticks(int'($urandom_range(0, 3)), 0);
	endtask

	task automatic random_run();
		wait_drained();
		send_gap_pct = quiet_tail ? 0 : 5 * int'($urandom_range(0, 3));
		recv_gap_pct = quiet_tail ? 0 : 3 * int'($urandom_range(0, 3));
		set_timing(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3),
			$urandom_range(0, 3), $urandom_range(0, 5), $urandom_range(0, 8),
			$urandom_range(0, 6), $urandom_range(0, 4), $urandom_range(0, 8),
			$urandom_range(0, 4));
		if ($urandom_range(0, 3) == 0)
			write_reg(cfg_index_t'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)), $urandom());
		run_sequence($urandom_range(0, 4) == 0);
	endtask

	// driver: hold the transaction while stalled, insert idle bursts between items
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			send_gap <= 0;
		end else begin
			if (item_valid && !item_stall)
				outputs_due = {outputs_due, sequence_tick(item)};
			if (!item_valid || !item_stall) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					item_valid <= 1'b0;
				end else if (tick_queue.size() != 0 && send_gap_pct != 0
						&& $urandom_range(0, 99) < send_gap_pct) begin
					send_gap <= $urandom_range(0, 17);
					item_valid <= 1'b0;
				end else if (tick_queue.size() != 0) begin
					item <= tick_queue.pop_front();
					item_valid <= 1'b1;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: compare each result transaction against the oldest one due
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			recv_gap <= 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (outputs_due.size() == 0) begin
					mismatches++;
					$error("result transaction with no tick outstanding");
				end else begin
					want = outputs_due.pop_front();
					check_field("tx_positive", 32'(want.tx_positive), 32'(result.tx_positive));
					check_field("tx_negative", 32'(want.tx_negative), 32'(result.tx_negative));
					check_field("transmit_mode", 32'(want.transmit_mode),
						32'(result.transmit_mode));
					check_field("polarize_on", 32'(want.polarize_on), 32'(result.polarize_on));
					check_field("ramp_strobe", 32'(want.ramp_strobe), 32'(result.ramp_strobe));
					check_field("sample_valid", 32'(want.sample_valid), 32'(result.sample_valid));
					check_field("captured_sample", 32'(want.captured_sample),
						32'(result.captured_sample));
					check_field("echo_number", 32'(want.echo_number), 32'(result.echo_number));
					check_field("last_of_echo", 32'(want.last_of_echo), 32'(result.last_of_echo));
					check_field("busy_res", 32'(want.busy_res), 32'(result.busy_res));
				end
			end
			if (recv_gap != 0) begin
				recv_gap <= recv_gap - 1;
				result_stall <= 1'b1;
			end else if (recv_gap_pct != 0 && $urandom_range(0, 99) < recv_gap_pct) begin
				recv_gap <= $urandom_range(0, 17);
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if ((item_valid && !item_stall) || (result_valid && !result_stall) || cfg_write) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("nmr_cpmg_pulse_sequencer_tb failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int goal;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// idle ticks under reset timing
		queue_tick(1'b0, '1);
		queue_tick(1'b0, '0);
		wait_drained();

		// lengths, interval and echo count zero, one sample point; spare indexes ignored
		set_timing(0, 0, 0, 0, 0, 0, 1, 0);
		write_reg(REG_SPARE_FIRST, '1);
		write_reg(REG_SPARE_LAST, 32'h5A5A_5A5A);
		queue_tick(1'b1, '0);
		queue_tick(1'b0, '1);
		queue_tick(1'b0, '1);
		queue_tick(1'b0, 12'($urandom()));
		wait_drained();

		// unit lengths, refused write mid-run, start while running
		send_gap_pct = 10;
		recv_gap_pct = 5;
		set_timing(1, 1, 1, 1, 1, 1, 2, 1);
		queue_tick(1'b1, 12'($urandom()));
		queue_ticks(5, 0);
		wait_drained();
		write_reg(cpmg_pkg::REG_POLARIZE, 32'd5);
		queue_tick(1'b1, 12'($urandom()));
		queue_ticks(8, 0);
		queue_tick(1'b0, 12'($urandom()));

		goal = stim_items + ITEM_GOAL * 2 / 5;
		while (stim_items < goal)
			random_run();

		// longest echo train with the widest carrier half cycle
		wait_drained();
		set_timing(32'h0000_FFFF, 0, 0, 0, 0, 1, 1, 32'h0000_00FF);
		run_sequence(1'b0);

		goal = stim_items + ITEM_GOAL * 2 / 5;
		while (stim_items < goal) begin
			quiet_tail = (goal - stim_items < 250);
			random_run();
		end

		// full-scale registers; the run stays in polarize until the end
		wait_drained();
		send_gap_pct = 0;
		recv_gap_pct = 0;
		set_timing(32'h0000_FFFF, 32'h0000_FFFF, 32'h00FF_FFFF, 32'hFFFF_FFFF,
			32'h00FF_FFFF, 32'h0000_FFFF, 32'(cpmg_pkg::BUFFER_DEPTH), 32'h0000_00FF);
		queue_tick(1'b1, 12'($urandom()));
		queue_ticks(40, 4);
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d transactions in %0d sequences, %0d ADC captures, %0d register writes",
			stim_items, runs_started, samples_taken, reg_writes);
		$display("timings spanned zero-length phases through full-scale registers, with idle bursts");
		if (mismatches == 0)
			$display("nmr_cpmg_pulse_sequencer_tb passed");
		else
			$display("nmr_cpmg_pulse_sequencer_tb failed");
		$finish;
	end

endmodule

// ===== nmr_cpmg_pulse_sequencer.f =====
rtl/core/cpmg_pkg.sv
rtl/core/nmr_cpmg_pulse_sequencer.sv
bench/nmr_cpmg_pulse_sequencer_tb.sv
